FILE: hdl/eul_pkg.sv
// Shared types, codes and the quarter-wave sine table for the Euler point rotator.
// Has no dependencies. Every other file in hdl imports it.
package eul_pkg;

   // Step item axis codes. Any code above AXIS_HOLD changes nothing.
   typedef enum logic [2:0] {
      AXIS_PLUS_X  = 3'd0,
      AXIS_PLUS_Y  = 3'd1,
      AXIS_PLUS_Z  = 3'd2,
      AXIS_MINUS_X = 3'd3,
      AXIS_MINUS_Y = 3'd4,
      AXIS_MINUS_Z = 3'd5,
      AXIS_HOLD    = 3'd6
   } axis_code_type;

   // Item kinds carried in tuser.
   localparam logic REQ_KIND_STEP  = 1'b0;
   localparam logic REQ_KIND_POINT = 1'b1;

   localparam int AXIS_BITS  = 3;
   localparam int STEP_BITS  = 16;
   localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd364;
   localparam int TABLE_LAST = 64;

   // Load enables for the two register stages of a pipelined unit.
   typedef struct packed {
      logic en_a;
      logic en_b;
   } eul_stage_en_type;

   // sin(k*pi/128) for k = 0..64, scaled by 65536.
   function automatic logic [16:0] sine_entry(input logic [6:0] idx);
      logic [16:0] v;
      case (idx)
         7'd0: v = 17'd0;      7'd1: v = 17'd1608;   7'd2: v = 17'd3216;
         7'd3: v = 17'd4821;   7'd4: v = 17'd6424;   7'd5: v = 17'd8022;
         7'd6: v = 17'd9616;   7'd7: v = 17'd11204;  7'd8: v = 17'd12785;
         7'd9: v = 17'd14359;  7'd10: v = 17'd15924; 7'd11: v = 17'd17479;
         7'd12: v = 17'd19024; 7'd13: v = 17'd20557; 7'd14: v = 17'd22078;
         7'd15: v = 17'd23586; 7'd16: v = 17'd25080; 7'd17: v = 17'd26558;
         7'd18: v = 17'd28020; 7'd19: v = 17'd29466; 7'd20: v = 17'd30893;
         7'd21: v = 17'd32303; 7'd22: v = 17'd33692; 7'd23: v = 17'd35062;
         7'd24: v = 17'd36410; 7'd25: v = 17'd37736; 7'd26: v = 17'd39040;
         7'd27: v = 17'd40320; 7'd28: v = 17'd41576; 7'd29: v = 17'd42806;
         7'd30: v = 17'd44011; 7'd31: v = 17'd45190; 7'd32: v = 17'd46341;
         7'd33: v = 17'd47464; 7'd34: v = 17'd48559; 7'd35: v = 17'd49624;
         7'd36: v = 17'd50660; 7'd37: v = 17'd51665; 7'd38: v = 17'd52639;
         7'd39: v = 17'd53581; 7'd40: v = 17'd54491; 7'd41: v = 17'd55368;
         7'd42: v = 17'd56212; 7'd43: v = 17'd57022; 7'd44: v = 17'd57798;
         7'd45: v = 17'd58538; 7'd46: v = 17'd59244; 7'd47: v = 17'd59914;
         7'd48: v = 17'd60547; 7'd49: v = 17'd61145; 7'd50: v = 17'd61705;
         7'd51: v = 17'd62228; 7'd52: v = 17'd62714; 7'd53: v = 17'd63162;
         7'd54: v = 17'd63572; 7'd55: v = 17'd63944; 7'd56: v = 17'd64277;
         7'd57: v = 17'd64571; 7'd58: v = 17'd64827; 7'd59: v = 17'd65043;
         7'd60: v = 17'd65220; 7'd61: v = 17'd65358; 7'd62: v = 17'd65457;
         7'd63: v = 17'd65516; 7'd64: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/eul_trig.sv
// Two-stage sine unit: quarter-wave table lookup with linear interpolation.
// Depends on eul_pkg for the sine table and the stage enable struct.
module eul_trig #(
   parameter int ANGLE_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                clock,
   input  eul_pkg::eul_stage_en_type           stage_en,
   input  logic [ANGLE_BITS-1:0]               phase,
   output logic signed [TRIG_FRAC_BITS+1:0]    value
);
   import eul_pkg::*;

   localparam int SEG_BITS = ANGLE_BITS - 8;
   localparam int SEG_W    = (SEG_BITS > 0) ? SEG_BITS : 1;
   localparam int R_W      = ANGLE_BITS - 1;
   localparam int EXT_W    = 17 + SEG_BITS;
   localparam int UP       = TRIG_FRAC_BITS - (16 + SEG_BITS);
   localparam int UP_S     = (UP >= 0) ? UP : 0;
   localparam int DN_S     = (UP < 0) ? -UP : 0;
   localparam int MAG_W    = TRIG_FRAC_BITS + 1;
   localparam int WORK_W   = EXT_W + UP_S + 1;
   localparam logic [R_W-1:0]    QUARTER = R_W'(1) << (ANGLE_BITS - 2);
   localparam logic [WORK_W-1:0] HALF    = (WORK_W'(1) << DN_S) >> 1;

   logic [1:0]        quad;
   logic [R_W-1:0]    r_low;
   logic [R_W-1:0]    r;
   logic [6:0]        idx;
   logic [6:0]        idx_next;
   logic [SEG_W-1:0]  frac;
   logic [16:0]       base;
   logic [16:0]       upper;
   logic [16:0]       delta;
   logic [EXT_W-1:0]  ext_in;
   logic [EXT_W-1:0]  ext_ff;
   logic              neg_in;
   logic              neg_ff;
   logic [WORK_W-1:0] work;
   logic [MAG_W-1:0]  mag;
   logic signed [TRIG_FRAC_BITS+1:0] value_in;
   logic signed [TRIG_FRAC_BITS+1:0] value_ff;

   // Fold the phase into the first quadrant and interpolate between entries.
   always_comb begin
      quad  = phase[ANGLE_BITS-1:ANGLE_BITS-2];
      r_low = {1'b0, phase[ANGLE_BITS-3:0]};
      r     = quad[0] ? (QUARTER - r_low) : r_low;
      idx   = 7'(r >> SEG_BITS);
      idx_next = 7'(idx + 7'd1);
      frac  = (SEG_BITS > 0) ? r[SEG_W-1:0] : '0;
      base  = sine_entry(idx);
      upper = (idx < 7'(TABLE_LAST)) ? sine_entry(idx_next) : base;
      delta = upper - base;
      ext_in = (EXT_W'(base) << SEG_BITS) + EXT_W'(EXT_W'(delta) * EXT_W'(frac));
      neg_in = quad[1];
   end

   // Rescale to the output fraction width, rounding half up, and apply the sign.
   always_comb begin
      if (UP >= 0) begin
         work = WORK_W'(ext_ff) << UP_S;
      end else begin
         work = (WORK_W'(ext_ff) + HALF) >> DN_S;
      end
      mag = work[MAG_W-1:0];
      value_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (stage_en.en_a) begin
         ext_ff <= ext_in;
         neg_ff <= neg_in;
      end
      if (stage_en.en_b) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

FILE: hdl/eul_rotate.sv
// Two-stage plane rotation: four products, then two rounded sums.
// Depends on eul_pkg for the stage enable struct.
module eul_rotate #(
   parameter int IN_W           = 24,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  eul_pkg::eul_stage_en_type        stage_en,
   input  logic signed [IN_W-1:0]           a,
   input  logic signed [IN_W-1:0]           b,
   input  logic signed [TRIG_FRAC_BITS+1:0] cos_v,
   input  logic signed [TRIG_FRAC_BITS+1:0] sin_v,
   output logic signed [IN_W+1:0]           a_out,
   output logic signed [IN_W+1:0]           b_out
);
   import eul_pkg::*;

   localparam int PROD_W = IN_W + TRIG_FRAC_BITS + 2;
   localparam int SUM_W  = PROD_W + 1;
   localparam int OUT_W  = IN_W + 2;
   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (TRIG_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [SUM_W-1:0]  sum_a;
   logic signed [SUM_W-1:0]  sum_b;
   logic signed [OUT_W-1:0]  a_out_ff;
   logic signed [OUT_W-1:0]  b_out_ff;

   // a' = a*c + b*s and b' = b*c - a*s, rounded half toward plus infinity.
   always_comb begin
      sum_a = (SUM_W'(ac_ff) + SUM_W'(bs_ff) + HALF) >>> TRIG_FRAC_BITS;
      sum_b = (SUM_W'(bc_ff) - SUM_W'(as_ff) + HALF) >>> TRIG_FRAC_BITS;
   end

   // Product stage, then sum stage.
   always_ff @(posedge clock) begin
      if (stage_en.en_a) begin
         ac_ff <= PROD_W'(a) * PROD_W'(cos_v);
         bs_ff <= PROD_W'(b) * PROD_W'(sin_v);
         as_ff <= PROD_W'(a) * PROD_W'(sin_v);
         bc_ff <= PROD_W'(b) * PROD_W'(cos_v);
      end
      if (stage_en.en_b) begin
         a_out_ff <= OUT_W'(sum_a);
         b_out_ff <= OUT_W'(sum_b);
      end
   end

   assign a_out = a_out_ff;
   assign b_out = b_out_ff;

endmodule

FILE: hdl/euler_xyz_point_rotator.sv
// Euler x-y-z point rotator: holds three angles and turns points about x, y, z.
// Depends on eul_pkg, eul_trig and eul_rotate.
// A point beat passes through stages 0 to 9 before it appears on rsp.
// Throughput: one beat per cycle while rsp_tready is high; a ten-stage valid
// pipeline where each stage advances when empty or when the next moves, so idle
// slots fill under stall. Step beats update the angle registers only.
// Reset (synchronous) clears angles and pipeline valids and sets turn_step to 364.
module euler_xyz_point_rotator #(
   parameter int ANGLE_BITS     = 16,
   parameter int COORD_BITS     = 24,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   // Configuration port.
   input  logic                          csr_wen,
   input  logic [eul_pkg::STEP_BITS-1:0] csr_wdata,
   // Request channel.
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: axis_code, point_x, point_y, point_z, zero fill.
   input  logic [((eul_pkg::AXIS_BITS + 3*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields: req_type.
   input  logic req_tuser,
   // Response channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: out_x, out_y, out_z, zero fill.
   output logic [((3*COORD_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Fields: clipped.
   output logic rsp_tuser
);
   import eul_pkg::*;

   localparam int RSP_W  = ((3*COORD_BITS + 7) / 8) * 8;
   localparam int STAGES = 10;
   localparam int TW     = TRIG_FRAC_BITS + 2;
   localparam int W1     = COORD_BITS + 2;
   localparam int W2     = COORD_BITS + 4;
   localparam int W3     = COORD_BITS + 6;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic signed [W3-1:0] COORD_MAX = (W3'(1) <<< (COORD_BITS - 1)) - W3'(1);
   localparam logic signed [W3-1:0] COORD_MIN = -(W3'(1) <<< (COORD_BITS - 1));

   // Control and configuration.
   logic [STAGES-1:0]     v_ff;
   logic [STAGES-1:0]     en;
   logic                  accept;
   logic                  point_in;
   logic [STEP_BITS-1:0]  turn_step_ff;
   logic [ANGLE_BITS-1:0] step_amt;
   axis_code_type         axis;
   logic [ANGLE_BITS-1:0] ang_x_ff, ang_y_ff, ang_z_ff;
   logic [ANGLE_BITS-1:0] ang_x_in, ang_y_in, ang_z_in;

   // Stage 0 payload.
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff, z0_ff;
   logic [ANGLE_BITS-1:0]        ax0_ff, ay0_ff, az0_ff;

   // Coordinate and trig delay lines.
   logic signed [COORD_BITS-1:0] x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff, x3_ff, x4_ff;
   logic signed [W1-1:0]         y4, z4, y5_ff, y6_ff;
   logic signed [W2-1:0]         x6, z6, z7_ff, z8_ff;
   logic signed [W3-1:0]         x8, y8;
   logic signed [TW-1:0]         cx, sx, cy, sy, cz, sz;
   logic signed [TW-1:0]         cy3_ff, sy3_ff, cy4_ff, sy4_ff;
   logic signed [TW-1:0]         cz3_ff, sz3_ff, cz4_ff, sz4_ff;
   logic signed [TW-1:0]         cz5_ff, sz5_ff, cz6_ff, sz6_ff;

   // Output stage.
   logic signed [COORD_BITS-1:0] ox_in, oy_in, oz_in;
   logic signed [COORD_BITS-1:0] ox_ff, oy_ff, oz_ff;
   logic                         clip_in, clip_ff;
   logic                         clip_x, clip_y, clip_z;

   eul_stage_en_type trig_en, rot_x_en, rot_y_en, rot_z_en;

   // Saturate a wide intermediate to the coordinate range.
   function automatic logic signed [COORD_BITS-1:0] clamp(input logic signed [W3-1:0] v,
                                                          output logic hit);
      logic signed [COORD_BITS-1:0] r;
      hit = 1'b1;
      if (v > COORD_MAX) begin
         r = COORD_BITS'(COORD_MAX);
      end else if (v < COORD_MIN) begin
         r = COORD_BITS'(COORD_MIN);
      end else begin
         r = COORD_BITS'(v);
         hit = 1'b0;
      end
      return r;
   endfunction

   // Each stage loads when it is empty or its contents move on.
   always_comb begin
      en[STAGES-1] = ~v_ff[STAGES-1] | rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign req_tready = en[0];
   assign accept     = req_tvalid & req_tready;
   assign point_in   = accept & (req_tuser == REQ_KIND_POINT);
   assign step_amt   = ANGLE_BITS'(turn_step_ff);
   assign axis       = axis_code_type'(req_tdata[AXIS_BITS-1:0]);

   // Angle update for a step beat.
   always_comb begin
      ang_x_in = ang_x_ff;
      ang_y_in = ang_y_ff;
      ang_z_in = ang_z_ff;
      if (accept && (req_tuser == REQ_KIND_STEP)) begin
         unique case (axis)
            AXIS_PLUS_X:  ang_x_in = ang_x_ff + step_amt;
            AXIS_PLUS_Y:  ang_y_in = ang_y_ff + step_amt;
            AXIS_PLUS_Z:  ang_z_in = ang_z_ff + step_amt;
            AXIS_MINUS_X: ang_x_in = ang_x_ff - step_amt;
            AXIS_MINUS_Y: ang_y_in = ang_y_ff - step_amt;
            AXIS_MINUS_Z: ang_z_in = ang_z_ff - step_amt;
            default: ;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         turn_step_ff <= STEP_RESET;
         ang_x_ff     <= '0;
         ang_y_ff     <= '0;
         ang_z_ff     <= '0;
      end else begin
         if (csr_wen) begin
            turn_step_ff <= csr_wdata;
         end
         ang_x_ff <= ang_x_in;
         ang_y_ff <= ang_y_in;
         ang_z_ff <= ang_z_in;
         if (en[0]) begin
            v_ff[0] <= point_in;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // Stage 0 captures the point with the angles in force at that beat.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         x0_ff  <= req_tdata[AXIS_BITS +: COORD_BITS];
         y0_ff  <= req_tdata[AXIS_BITS + COORD_BITS +: COORD_BITS];
         z0_ff  <= req_tdata[AXIS_BITS + 2*COORD_BITS +: COORD_BITS];
         ax0_ff <= ang_x_ff;
         ay0_ff <= ang_y_ff;
         az0_ff <= ang_z_ff;
      end
   end

   // Sine and cosine of all three angles over stages 1 and 2.
   assign trig_en  = '{en_a: en[1], en_b: en[2]};
   assign rot_x_en = '{en_a: en[3], en_b: en[4]};
   assign rot_y_en = '{en_a: en[5], en_b: en[6]};
   assign rot_z_en = '{en_a: en[7], en_b: en[8]};

   eul_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_x (
      .clock(clock), .stage_en(trig_en), .phase(ax0_ff + QUARTER), .value(cx));
   eul_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_x (
      .clock(clock), .stage_en(trig_en), .phase(ax0_ff), .value(sx));
   eul_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_y (
      .clock(clock), .stage_en(trig_en), .phase(ay0_ff + QUARTER), .value(cy));
   eul_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_y (
      .clock(clock), .stage_en(trig_en), .phase(ay0_ff), .value(sy));
   eul_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos_z (
      .clock(clock), .stage_en(trig_en), .phase(az0_ff + QUARTER), .value(cz));
   eul_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin_z (
      .clock(clock), .stage_en(trig_en), .phase(az0_ff), .value(sz));

   // Delay lines that keep coordinates and later trig values beside their point.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         x1_ff <= x0_ff;
         y1_ff <= y0_ff;
         z1_ff <= z0_ff;
      end
      if (en[2]) begin
         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         z2_ff <= z1_ff;
      end
      if (en[3]) begin
         x3_ff  <= x2_ff;
         cy3_ff <= cy;
         sy3_ff <= sy;
         cz3_ff <= cz;
         sz3_ff <= sz;
      end
      if (en[4]) begin
         x4_ff  <= x3_ff;
         cy4_ff <= cy3_ff;
         sy4_ff <= sy3_ff;
         cz4_ff <= cz3_ff;
         sz4_ff <= sz3_ff;
      end
      if (en[5]) begin
         y5_ff  <= y4;
         cz5_ff <= cz4_ff;
         sz5_ff <= sz4_ff;
      end
      if (en[6]) begin
         y6_ff  <= y5_ff;
         cz6_ff <= cz5_ff;
         sz6_ff <= sz5_ff;
      end
      if (en[7]) begin
         z7_ff <= z6;
      end
      if (en[8]) begin
         z8_ff <= z7_ff;
      end
   end

   // Rotation about x: y and z, stages 3 and 4.
   eul_rotate #(.IN_W(COORD_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
      .clock(clock), .stage_en(rot_x_en), .a(y2_ff), .b(z2_ff),
      .cos_v(cx), .sin_v(sx), .a_out(y4), .b_out(z4));

   // Rotation about y: x and z, stages 5 and 6.
   eul_rotate #(.IN_W(W1), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
      .clock(clock), .stage_en(rot_y_en), .a(W1'(x4_ff)), .b(z4),
      .cos_v(cy4_ff), .sin_v(sy4_ff), .a_out(x6), .b_out(z6));

   // Rotation about z: x and y with the sine negated, stages 7 and 8.
   eul_rotate #(.IN_W(W2), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
      .clock(clock), .stage_en(rot_z_en), .a(x6), .b(W2'(y6_ff)),
      .cos_v(cz6_ff), .sin_v(-sz6_ff), .a_out(x8), .b_out(y8));

   // Saturation into the output register.
   always_comb begin
      ox_in   = clamp(x8, clip_x);
      oy_in   = clamp(y8, clip_y);
      oz_in   = clamp(W3'(z8_ff), clip_z);
      clip_in = clip_x | clip_y | clip_z;
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         oz_ff   <= oz_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_tvalid = v_ff[STAGES-1];
   assign rsp_tdata  = RSP_W'({oz_ff, oy_ff, ox_ff});
   assign rsp_tuser  = clip_ff;

endmodule

FILE: bench/rotator_checker.sv
// Checker for the Euler x-y-z point rotator: mirrors the angle state, predicts each
// rotated point from accepted request beats and compares response beats in order.
// Depends on eul_pkg.
module rotator_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [79:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic         rsp_tuser,
   output int           fail_count,
   output int           pending_points,
   output int           points_seen,
   output int           clipped_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import eul_pkg::*;

   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
      logic        clip;
   } rotated_point_type;

   rotated_point_type rotated_q[$];
   logic [15:0] step_size;
   logic [15:0] ang_x, ang_y, ang_z;

   // Sine of a 16-bit phase in Q1.14 from the quarter-wave table.
   function automatic longint sine_q14(input logic [15:0] phase);
      logic [1:0]  quad;
      logic [14:0] r;
      int          idx;
      longint      ext, mag;
      quad = phase[15:14];
      r = {1'b0, phase[13:0]};
      if (quad[0])
         r = 15'd16384 - r;
      idx = r >> 8;
      ext = longint'(sine_entry(7'(idx))) << 8;
      if (idx < TABLE_LAST)
         ext += (longint'(sine_entry(7'(idx + 1))) - longint'(sine_entry(7'(idx))))
                * longint'(r[7:0]);
      mag = (ext + (64'sd1 <<< 9)) >>> 10;
      return quad[1] ? -mag : mag;
   endfunction

   // Rounded sum of two products, half toward plus infinity.
   function automatic longint mix_round(input longint a, ka, b, kb);
      return (a * ka + b * kb + 64'sd8192) >>> 14;
   endfunction

   function automatic logic [23:0] clamp24(input longint v, inout logic clip);
      if (v < -64'sd8388608) begin
         clip = 1'b1;
         return 24'h800000;
      end
      if (v > 64'sd8388607) begin
         clip = 1'b1;
         return 24'h7fffff;
      end
      return v[23:0];
   endfunction

   function automatic rotated_point_type rotate_point(input logic [23:0] px, py, pz);
      longint x, y, z, c, s, t;
      rotated_point_type p;
      logic clip;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      clip = 1'b0;
      c = sine_q14(ang_x + 16'h4000);
      s = sine_q14(ang_x);
      t = mix_round(y, c, z, s);
      z = mix_round(y, -s, z, c);
      y = t;
      c = sine_q14(ang_y + 16'h4000);
      s = sine_q14(ang_y);
      t = mix_round(x, c, z, s);
      z = mix_round(x, -s, z, c);
      x = t;
      c = sine_q14(ang_z + 16'h4000);
      s = sine_q14(ang_z);
      t = mix_round(x, c, y, -s);
      y = mix_round(x, s, y, c);
      x = t;
      p.x = clamp24(x, clip);
      p.y = clamp24(y, clip);
      p.z = clamp24(z, clip);
      p.clip = clip;
      return p;
   endfunction

   // Track state, predict on request beats, compare on response beats.
   always @(posedge clock) begin
      rotated_point_type want;
      if (reset) begin
         step_size <= STEP_RESET;
         ang_x <= '0;
         ang_y <= '0;
         ang_z <= '0;
         rotated_q.delete();
         fail_count <= 0;
         points_seen <= 0;
         clipped_seen <= 0;
      end else begin
         if (csr_wen)
            step_size <= csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_KIND_POINT) begin
               rotated_q.push_back(rotate_point(req_tdata[26:3], req_tdata[50:27],
                                                req_tdata[74:51]));
            end else begin
               case (axis_code_type'(req_tdata[2:0]))
                  AXIS_PLUS_X:  ang_x <= ang_x + step_size;
                  AXIS_PLUS_Y:  ang_y <= ang_y + step_size;
                  AXIS_PLUS_Z:  ang_z <= ang_z + step_size;
                  AXIS_MINUS_X: ang_x <= ang_x - step_size;
                  AXIS_MINUS_Y: ang_y <= ang_y - step_size;
                  AXIS_MINUS_Z: ang_z <= ang_z - step_size;
                  default: ;
               endcase
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rotated_q.size() == 0) begin
               $error("unexpected response beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = rotated_q.pop_front();
               points_seen <= points_seen + 1;
               if (rsp_tuser)
                  clipped_seen <= clipped_seen + 1;
               if (rsp_tdata[23:0] !== want.x || rsp_tdata[47:24] !== want.y ||
                   rsp_tdata[71:48] !== want.z || rsp_tuser !== want.clip) begin
                  if (rsp_tdata[23:0] !== want.x)
                     $error("out_x expected %h got %h", want.x, rsp_tdata[23:0]);
                  if (rsp_tdata[47:24] !== want.y)
                     $error("out_y expected %h got %h", want.y, rsp_tdata[47:24]);
                  if (rsp_tdata[71:48] !== want.z)
                     $error("out_z expected %h got %h", want.z, rsp_tdata[71:48]);
                  if (rsp_tuser !== want.clip)
                     $error("clipped expected %b got %b", want.clip, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_points = rotated_q.size();
endmodule

FILE: bench/tb_top.sv
// Top of the point rotator testbench: clock, reset, register writes and stimulus.
// Depends on eul_pkg, euler_xyz_point_rotator and rotator_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import eul_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count, pending_points, points_seen, clipped_seen;
   int          send_idle_pct, recv_idle_pct;
   bit          recv_hold;
   int          beats_sent;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   euler_xyz_point_rotator dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   rotator_checker u_checker (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .fail_count(fail_count),
      .pending_points(pending_points), .points_seen(points_seen),
      .clipped_seen(clipped_seen)
   );

   // Receiver: random ready, or held low during a long stall.
   always @(negedge clock)
      rsp_tready <= !reset && !recv_hold && ($urandom_range(99) >= recv_idle_pct);

   // Offer one beat, with random idle cycles before it, and wait for its acceptance.
   // The valid flag is driven with blocking writes so that dropping it after one beat
   // and raising it for the next at the same falling edge leaves a single final value.
   task automatic send_beat(input logic kind, input logic [2:0] axis,
                            input logic [23:0] px, py, pz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser <= kind;
      req_tdata <= {5'b0, pz, py, px, axis};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      beats_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Drain results, let the pipeline settle, then write the step register.
   task automatic write_step(input logic [15:0] value);
      while (pending_points != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(9))
         0: return 24'h7fffff;
         1: return 24'h800000;
         2, 3: return 24'($urandom);
         default: return 24'($signed(12'($urandom)));
      endcase
   endfunction

   task automatic random_beats(input int count);
      repeat (count) begin
         if ($urandom_range(9) < 2)
            send_beat(REQ_KIND_STEP, 3'($urandom_range(7)), 24'($urandom), 24'($urandom),
                      24'($urandom));
         else
            send_beat(REQ_KIND_POINT, 3'($urandom), rand_coord(), rand_coord(),
                      rand_coord());
      end
   endtask

   initial begin
      #2ms;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int k;
      beats_sent = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: points at the reset angles, extremes, every axis code.
      send_beat(REQ_KIND_POINT, AXIS_PLUS_X, 24'h7fffff, 24'h800000, 24'h000100);
      send_beat(REQ_KIND_POINT, AXIS_HOLD, 24'h800000, 24'h7fffff, 24'h7fffff);
      for (k = 0; k < 8; k++) begin
         send_beat(REQ_KIND_STEP, 3'(k), 24'hffffff, 24'hffffff, 24'hffffff);
         send_beat(REQ_KIND_POINT, 3'(7 - k), 24'h7fffff, 24'h7fffff, 24'h800000);
      end
      write_step(16'hffff);
      send_beat(REQ_KIND_STEP, AXIS_PLUS_Y, 24'h0, 24'h0, 24'h0);
      send_beat(REQ_KIND_STEP, AXIS_MINUS_Z, 24'h0, 24'h0, 24'h0);
      send_beat(REQ_KIND_POINT, AXIS_HOLD, 24'h7fffff, 24'h800000, 24'h7fffff);
      write_step(16'h4000);
      send_beat(REQ_KIND_STEP, AXIS_PLUS_Z, 24'h0, 24'h0, 24'h0);
      send_beat(REQ_KIND_POINT, AXIS_HOLD, 24'h800000, 24'h800000, 24'h800000);

      // Random phases under changing handshake pressure and step sizes.
      send_idle_pct = 27;
      recv_idle_pct = 75;
      write_step(16'd0);
      random_beats(150);
      write_step(16'($urandom));
      random_beats(200);
      send_idle_pct = 75;
      recv_idle_pct = 27;
      write_step(16'h8000);
      random_beats(150);
      write_step(16'd1);
      random_beats(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_step(16'($urandom));
      // Long receiver stall while the sender keeps offering beats.
      fork
         begin
            recv_hold = 1;
            repeat (60) @(negedge clock);
            recv_hold = 0;
         end
         random_beats(60);
      join
      // Sender pauses until every point has come back.
      while (pending_points != 0)
         @(negedge clock);
      random_beats(200);
      write_step(16'hffff);
      random_beats(150);

      while (pending_points != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d beats; %0d rotated points checked, %0d of them clipped.",
               beats_sent, points_seen, clipped_seen);
      $display("Step sizes 0 to 65535 with all axis codes under mixed stalls.");
      if (fail_count == 0 && pending_points == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
